### src/rv32m_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32m_pkg
// Shared types and constants for the RV32M multiply/divide unit.
// ----------------------------------------------------------------------------
package rv32m_pkg;

    localparam int XLEN     = 32;
    localparam int OP_W     = 3;
    localparam int RD_W     = 5;
    localparam int DIV_BPS  = 2;                 // quotient bits per divider stage
    localparam int DIV_STG  = XLEN / DIV_BPS;    // divider stages

    localparam logic [OP_W-1:0] OP_MUL    = 3'd0;
    localparam logic [OP_W-1:0] OP_MULH   = 3'd1;
    localparam logic [OP_W-1:0] OP_MULHSU = 3'd2;
    localparam logic [OP_W-1:0] OP_MULHU  = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV    = 3'd4;
    localparam logic [OP_W-1:0] OP_DIVU   = 3'd5;
    localparam logic [OP_W-1:0] OP_REM    = 3'd6;
    localparam logic [OP_W-1:0] OP_REMU   = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0] action;
        logic [XLEN-1:0] operand_a;
        logic [XLEN-1:0] operand_b;
        logic [RD_W-1:0] dest_reg;
    } md_in_t;

    typedef struct packed {
        logic [XLEN-1:0] result;
        logic [RD_W-1:0] dest_reg_out;
    } md_out_t;

    // Per-word control carried down the pipe
    typedef struct packed {
        logic [OP_W-1:0] action;
        logic            is_div;
        logic            div_zero;
        logic            neg_q;
        logic            neg_r;
        logic [XLEN-1:0] orig_a;
        logic [RD_W-1:0] rd;
    } md_ctl_t;

endpackage

### src/rv32m_div_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32m_div_stage
// One restoring-division step group: DIV_BPS quotient bits per stage.
// ----------------------------------------------------------------------------
module rv32m_div_stage
    import rv32m_pkg::*;
(
    input  logic [XLEN-1:0] rem_in,
    input  logic [XLEN-1:0] quo_in,
    input  logic [XLEN-1:0] dvs,
    output logic [XLEN-1:0] rem_out,
    output logic [XLEN-1:0] quo_out
);

    always_comb
    begin
        logic [XLEN:0]   r;
        logic [XLEN:0]   d;
        logic [XLEN-1:0] q;
        r = {1'b0, rem_in};
        q = quo_in;
        for (int i = 0; i < DIV_BPS; i++)
        begin
            r = {r[XLEN-1:0], q[XLEN-1]};
            q = {q[XLEN-2:0], 1'b0};
            d = r - {1'b0, dvs};
            if (!d[XLEN])
            begin
                r    = d;
                q[0] = 1'b1;
            end
        end
        rem_out = r[XLEN-1:0];
        quo_out = q;
    end

endmodule

### src/rv32m_mul_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32m_mul_unit
// 33x33 signed product as four 17x17-ish partials, summed over two stages.
// ----------------------------------------------------------------------------
module rv32m_mul_unit
    import rv32m_pkg::*;
(
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [XLEN:0]  a,
    input  logic signed [XLEN:0]  b,
    output logic [2*XLEN-1:0]     prod
);

    localparam int H = XLEN / 2;

    logic signed [2*XLEN+1:0] pll_reg, plh_reg, phl_reg, phh_reg;
    logic signed [2*XLEN+1:0] sum_reg;

    // split into unsigned low halves and signed high parts
    logic signed [H:0]      a_lo, b_lo;
    logic signed [H:0]      a_hi, b_hi;
    assign a_lo = {1'b0, a[H-1:0]};
    assign b_lo = {1'b0, b[H-1:0]};
    assign a_hi = a[XLEN:H];
    assign b_hi = b[XLEN:H];

    // full-width partial products; operands widen before the multiply
    logic signed [2*H+1:0]  m_ll, m_lh, m_hl, m_hh;
    assign m_ll = a_lo * b_lo;
    assign m_lh = a_lo * b_hi;
    assign m_hl = a_hi * b_lo;
    assign m_hh = a_hi * b_hi;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pll_reg <= (2*XLEN+2)'(m_ll);
            plh_reg <= (2*XLEN+2)'(m_lh) <<< H;
            phl_reg <= (2*XLEN+2)'(m_hl) <<< H;
            phh_reg <= (2*XLEN+2)'(m_hh) <<< (2*H);
            sum_reg <= pll_reg + plh_reg + phl_reg + phh_reg;
        end
    end

    assign prod = sum_reg[2*XLEN-1:0];

endmodule

### src/rv32m_multiply_divide_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32m_multiply_divide_unit_top
// Fully pipelined RV32M execution unit: MUL/MULH/MULHSU/MULHU and
// DIV/DIVU/REM/REMU, one word per cycle.
// ----------------------------------------------------------------------------
// Channel  Signals                   Direction  Word type
// in       in_valid/in_ready/in_data  sink      md_in_t
// out      out_valid/out_ready/out_data source  md_out_t
//
// One word enters per cycle while the output is not stalled. Every operation
// passes the prepare register, DIV_STG divider stages of DIV_BPS bits and
// the fix-up folded into the output register. The divider array sets the
// depth; the multiplier rides alongside in the first stages and its
// product is carried down.
// Reset clears only the valid bits. The whole pipe advances together when
// the output register is empty or being taken; a stall holds every stage,
// so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module rv32m_multiply_divide_unit_top
    import rv32m_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  md_in_t  in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output md_out_t out_data
);

    localparam int NS = DIV_STG + 1;   // register stages before fix-up

    logic adv;
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    // ---- stage 0: prepare operands --------------------------------------
    logic              v_reg   [NS];
    md_ctl_t           ctl_reg [NS];
    logic [XLEN-1:0]   rem_reg [NS];
    logic [XLEN-1:0]   quo_reg [NS];
    logic [XLEN-1:0]   dvs_reg [NS];

    logic              sa, sb, sgn_op;
    logic [XLEN-1:0]   ma, mb;
    logic signed [XLEN:0] mul_a, mul_b;
    md_ctl_t           ctl_next;
    logic [2*XLEN-1:0] prod;

    always_comb
    begin
        sgn_op = (in_data.action == OP_DIV) || (in_data.action == OP_REM);
        sa     = in_data.operand_a[XLEN-1];
        sb     = in_data.operand_b[XLEN-1];
        ma     = (sgn_op && sa) ? (XLEN)'(-in_data.operand_a) : in_data.operand_a;
        mb     = (sgn_op && sb) ? (XLEN)'(-in_data.operand_b) : in_data.operand_b;
        // sign-extend a for MULH/MULHSU and b for MULH only, zero-extend otherwise
        mul_a  = {(in_data.action == OP_MULH || in_data.action == OP_MULHSU) && sa,
                  in_data.operand_a};
        mul_b  = {(in_data.action == OP_MULH) && sb, in_data.operand_b};
        ctl_next.action   = in_data.action;
        ctl_next.is_div   = in_data.action[2];
        ctl_next.div_zero = (in_data.operand_b == '0);
        ctl_next.neg_q    = sgn_op && (sa != sb);
        ctl_next.neg_r    = sgn_op && sa;
        ctl_next.orig_a   = in_data.operand_a;
        ctl_next.rd       = in_data.dest_reg;
    end

    rv32m_mul_unit u_mul (
        .clk  (clk),
        .en   (adv),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NS; s++)
                v_reg[s] <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s < NS; s++)
                v_reg[s] <= v_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_reg[0] <= ctl_next;
            rem_reg[0] <= '0;
            quo_reg[0] <= ma;
            dvs_reg[0] <= mb;
        end
    end

    // ---- divider stages ---------------------------------------------------
    // product emerges from the partial and sum registers; hold it in carried registers
    logic [2*XLEN-1:0] prod_pipe_reg [NS-2];

    genvar g;
    generate
        for (g = 1; g < NS; g++)
        begin : g_div
            logic [XLEN-1:0] r_n, q_n;
            rv32m_div_stage u_stg (
                .rem_in  (rem_reg[g-1]),
                .quo_in  (quo_reg[g-1]),
                .dvs     (dvs_reg[g-1]),
                .rem_out (r_n),
                .quo_out (q_n)
            );
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    ctl_reg[g] <= ctl_reg[g-1];
                    rem_reg[g] <= r_n;
                    quo_reg[g] <= q_n;
                    dvs_reg[g] <= dvs_reg[g-1];
                end
            end
        end
    endgenerate

    // product valid aligned to stage 1; carry it to stage NS-1
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_pipe_reg[0] <= prod;
            for (int s = 1; s < NS-2; s++)
                prod_pipe_reg[s] <= prod_pipe_reg[s-1];
        end
    end

    // ---- fix-up and output register --------------------------------------
    md_ctl_t         c;
    logic [XLEN-1:0] q, r, res_next;
    logic [2*XLEN-1:0] p;

    always_comb
    begin
        c = ctl_reg[NS-1];
        q = c.neg_q ? (XLEN)'(-quo_reg[NS-1]) : quo_reg[NS-1];
        r = c.neg_r ? (XLEN)'(-rem_reg[NS-1]) : rem_reg[NS-1];
        p = prod_pipe_reg[NS-3];
        unique case (c.action)
            OP_MUL:                     res_next = p[XLEN-1:0];
            OP_MULH, OP_MULHSU, OP_MULHU: res_next = p[2*XLEN-1:XLEN];
            OP_DIV, OP_DIVU:            res_next = c.div_zero ? '1 : q;
            default:                    res_next = c.div_zero ? c.orig_a : r;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (adv)
            out_valid <= v_reg[NS-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data.result       <= res_next;
            out_data.dest_reg_out <= c.rd;
        end
    end

endmodule
